// ===== sv/zoom_pkg.sv =====
// Package for the 2x midpoint zoom block: field widths, defaults and result slot codes.
// No dependencies; the top level zoom_2x_interpolator takes everything it needs from here.
package zoom_pkg;

   localparam int PIXEL_W            = 8;
   localparam int COORD_W            = 9;
   localparam int CFG_W              = 9;
   localparam int RSP_TDATA_W        = 32;
   localparam int DEFAULT_MAX_WINDOW = 256;
   localparam int WINDOW_RESET       = 256;

   // Result slots of one source pixel, in emission order
   localparam int SLOT_W        = 4;
   localparam int SLOT_ROW_MID  = 0;   // (2k, 2l-1)
   localparam int SLOT_COPY     = 1;   // (2k, 2l)
   localparam int SLOT_DIAG     = 2;   // (2k-1, 2l-1)
   localparam int SLOT_VERT     = 3;   // (2k-1, 2l)

   typedef logic [SLOT_W-1:0] slot_mask_type;

endpackage

// ===== sv/zoom_2x_interpolator.sv =====
// Top level of the 2x midpoint zoom: line buffer memory, result sequencer and output register.
// Depends on zoom_pkg for widths, defaults and result slot codes.
//
// Path: a transaction loads the pixel into the work stage, whose results go through the
//   output register. Throughput: one result per cycle while rsp_tready does not stall the
//   single output register; a pixel gives 1 to 4 results (4 in the image interior); the next
//   pixel is taken in the cycle its predecessor hands over its last result.
// Reset (synchronous, active high): clears position, sequencer and output valid, sets the
//   window size to min(256, MAX_WINDOW); the line buffer is not cleared and holds its data.
module zoom_2x_interpolator #(
   parameter int MAX_WINDOW = zoom_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: window_size
   input  logic                              csr_we,
   input  logic [zoom_pkg::CFG_W-1:0]        csr_wdata,
   // source pixels
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [zoom_pkg::PIXEL_W-1:0]      req_tdata,   // [7:0] pixel
   // zoomed results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [zoom_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [8:0] out_row, [17:9] out_col,
                                                          // [25:18] value, [31:26] zero
   output logic                              rsp_tlast,   // run_end
   output logic                              rsp_tuser    // image_end
);

   localparam int PW = zoom_pkg::PIXEL_W;
   localparam int CW = zoom_pkg::COORD_W;
   localparam int IW = $clog2(MAX_WINDOW);   // position / line buffer index width
   localparam int RESET_SIDE = (zoom_pkg::WINDOW_RESET > MAX_WINDOW) ?
                               MAX_WINDOW : zoom_pkg::WINDOW_RESET;
   localparam int PAD_W = zoom_pkg::RSP_TDATA_W - 2 * CW - PW;

   // ------------------------------------------------------------------
   // Window size and source position
   // ------------------------------------------------------------------
   logic [IW-1:0] last_ff, last_in;     // S-1, clipped to the buffer depth
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] col_ff, col_in;
   logic          req_accept;

   assign req_accept = req_tvalid && req_tready;

   // Clip the written size to 1..MAX_WINDOW and keep S-1
   always_comb begin
      if (csr_wdata == '0) begin
         last_in = '0;
      end else if (32'(csr_wdata) > MAX_WINDOW) begin
         last_in = IW'(MAX_WINDOW - 1);
      end else begin
         last_in = IW'(csr_wdata - 1'b1);
      end
   end

   // Advance along the row, wrap at the end of the row and of the image
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (col_ff == last_ff) begin
         col_in = '0;
         row_in = (row_ff == last_ff) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= IW'(RESET_SIDE - 1);
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (csr_we) begin
         // any write restarts the image at (0,0)
         last_ff <= last_in;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (req_accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // ------------------------------------------------------------------
   // Line buffer: previous source row. Read-first, so the pixel written
   // at column l in this transaction returns the previous row's value.
   // ------------------------------------------------------------------
   logic [PW-1:0] line_mem [MAX_WINDOW];
   logic [PW-1:0] up_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_ff            <= line_mem[col_ff];
         line_mem[col_ff] <= req_tdata;
      end
   end

   // ------------------------------------------------------------------
   // Work stage: one pixel and its neighbourhood while its results go out
   // ------------------------------------------------------------------
   logic [PW-1:0]         px_ff;        // current pixel
   logic [PW-1:0]         lc_ff;        // left neighbour in the current row
   logic [PW-1:0]         lp_ff;        // left neighbour in the previous row
   logic [CW-1:0]         row_even_ff;  // 2k
   logic [CW-1:0]         col_even_ff;  // 2l
   logic                  img_end_ff;
   zoom_pkg::slot_mask_type mask_ff, mask_in, slot_sel, mask_rest;
   logic                  out_load;
   logic                  emit;

   assign out_load  = !rsp_tvalid || rsp_tready;
   assign slot_sel  = mask_ff & (~mask_ff + 1'b1);    // lowest pending slot
   assign mask_rest = mask_ff & ~slot_sel;
   assign emit      = (mask_ff != '0) && out_load;

   // Take a new pixel when idle or as the last result leaves
   assign req_tready = (mask_ff == '0) || (out_load && (mask_rest == '0));

   always_comb begin
      mask_in = '0;
      mask_in[zoom_pkg::SLOT_ROW_MID] = (col_ff != '0);
      mask_in[zoom_pkg::SLOT_COPY]    = 1'b1;
      mask_in[zoom_pkg::SLOT_DIAG]    = (row_ff != '0) && (col_ff != '0);
      mask_in[zoom_pkg::SLOT_VERT]    = (row_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (req_accept) begin
         mask_ff <= mask_in;
      end else if (emit) begin
         mask_ff <= mask_rest;
      end
   end

   // Shift the neighbourhood along: the outgoing pixel and its up value
   // become the left neighbours of the incoming one
   always_ff @(posedge clock) begin
      if (req_accept) begin
         px_ff       <= req_tdata;
         lc_ff       <= px_ff;
         lp_ff       <= up_ff;
         row_even_ff <= CW'(row_ff) << 1;
         col_even_ff <= CW'(col_ff) << 1;
         img_end_ff  <= (row_ff == last_ff) && (col_ff == last_ff);
      end
   end

   // Midpoints
   logic [PW-1:0] row_mid, up_mid, diag_mid, vert_mid;

   assign row_mid  = PW'((9'(lc_ff)  + 9'(px_ff))   >> 1);
   assign up_mid   = PW'((9'(lp_ff)  + 9'(up_ff))   >> 1);
   assign diag_mid = PW'((9'(up_mid) + 9'(row_mid)) >> 1);
   assign vert_mid = PW'((9'(up_ff)  + 9'(px_ff))   >> 1);

   // Select the result for the pending slot
   logic [CW-1:0] sel_row, sel_col;
   logic [PW-1:0] sel_val;

   always_comb begin
      sel_row = row_even_ff;
      sel_col = col_even_ff;
      sel_val = px_ff;
      if (slot_sel[zoom_pkg::SLOT_ROW_MID]) begin
         sel_col = col_even_ff - 1'b1;
         sel_val = row_mid;
      end else if (slot_sel[zoom_pkg::SLOT_DIAG]) begin
         sel_row = row_even_ff - 1'b1;
         sel_col = col_even_ff - 1'b1;
         sel_val = diag_mid;
      end else if (slot_sel[zoom_pkg::SLOT_VERT]) begin
         sel_row = row_even_ff - 1'b1;
         sel_val = vert_mid;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_row_ff, rsp_col_ff;
   logic [PW-1:0] rsp_val_ff;
   logic          rsp_last_ff, rsp_img_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= (mask_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff  <= sel_row;
         rsp_col_ff  <= sel_col;
         rsp_val_ff  <= sel_val;
         rsp_last_ff <= (mask_rest == '0);
         rsp_img_ff  <= (mask_rest == '0) && img_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_val_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_img_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // every accepted pixel leaves at least its copied value pending
   a_copy_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept && !csr_we |=> mask_ff[zoom_pkg::SLOT_COPY])
      else $error("copy slot missing after pixel transaction");

   // a diagonal result always comes with a vertical one
   a_diag_vert: assert property (@(posedge clock) disable iff (reset)
      mask_ff[zoom_pkg::SLOT_DIAG] |-> mask_ff[zoom_pkg::SLOT_VERT])
      else $error("diagonal result pending without vertical result");

   // the image end only marks the last result of a pixel
   a_img_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image end flag without run end");

   // no new pixel while more than one result of the current one waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0) && (mask_rest != '0) |-> !req_tready)
      else $error("pixel accepted over pending results");

endmodule
